FILE: rtl/mccs_pkg.sv
// Shared types and constants for the minimum coin change solver.
// Holds operation and status codes, the control word layout and the microprogram.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mccs_pkg;

    // Default sizing handed to the top level parameters
    localparam int DEF_MAX_COINS  = 16;
    localparam int DEF_MAX_AMOUNT = 1023;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int VAL_W  = 10;
    localparam int ST_W   = 2;
    localparam int BEST_W = 11;
    localparam int AMT_W  = VAL_W + 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_UNREACH  = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECT   = 2'd2;
    localparam logic [ST_W-1:0] ST_NO_COINS = 2'd3;

    // Best-count code for an amount that cannot be made
    localparam logic [BEST_W-1:0] BEST_UNREACH = 11'd2047;

    // Datapath actions
    typedef enum logic [2:0] {
        A_NONE,
        A_ACCEPT,
        A_BEST_INIT,
        A_COIN_RD,
        A_TBL_RD,
        A_BEST_UPD,
        A_TBL_WR,
        A_RESULT
    } act_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_DONE_NOW,
        C_AMT_GT_TGT,
        C_K_DONE,
        C_COIN_SKIP
    } cond_t;

    // Handshake a step waits on before it fires
    typedef enum logic [1:0] {
        W_NONE,
        W_INPUT,
        W_OUTPUT
    } wt_t;

    typedef logic [2:0] upc_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        wt_t   wt;
        upc_t  jump;
    } ucode_t;

    // Step addresses
    localparam upc_t U_WAIT      = 3'd0;
    localparam upc_t U_AMT_TEST  = 3'd1;
    localparam upc_t U_AMT_INIT  = 3'd2;
    localparam upc_t U_COIN_TEST = 3'd3;
    localparam upc_t U_COIN_CHK  = 3'd4;
    localparam upc_t U_COIN_UPD  = 3'd5;
    localparam upc_t U_WRITE     = 3'd6;
    localparam upc_t U_FINISH    = 3'd7;

    // Microprogram: next step is jump when cond holds, else the following step
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        unique case (addr)
            U_WAIT:      w = '{A_ACCEPT,    C_DONE_NOW,   W_INPUT,  U_WAIT};
            U_AMT_TEST:  w = '{A_NONE,      C_AMT_GT_TGT, W_NONE,   U_FINISH};
            U_AMT_INIT:  w = '{A_BEST_INIT, C_NEVER,      W_NONE,   U_WAIT};
            U_COIN_TEST: w = '{A_COIN_RD,   C_K_DONE,     W_NONE,   U_WRITE};
            U_COIN_CHK:  w = '{A_TBL_RD,    C_COIN_SKIP,  W_NONE,   U_COIN_TEST};
            U_COIN_UPD:  w = '{A_BEST_UPD,  C_ALWAYS,     W_NONE,   U_COIN_TEST};
            U_WRITE:     w = '{A_TBL_WR,    C_ALWAYS,     W_NONE,   U_AMT_TEST};
            U_FINISH:    w = '{A_RESULT,    C_ALWAYS,     W_OUTPUT, U_WAIT};
            default:     w = '{A_NONE,      C_ALWAYS,     W_NONE,   U_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/min_coin_change_solver.sv
// Minimum coin change solver: microcoded sequencer, coin store and best-count table.
// Depends on mccs_pkg for codes, the control word type and the microprogram.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one item: operation, coin_value,
//   target_amount. Result channel (m_valid/m_ready) returns exactly one item
//   per input item: min_coins and status.
//   Add coin, clear and the unused code finish when they are taken; the
//   result shows in the next cycle. A solve that cannot start (no coins
//   loaded, target above MAX_AMOUNT) also finishes when it is taken.
//   A solve walks amounts 1..target; per amount it tests the amount, sets
//   the best count to unreachable, then per coin reads the coin, reads the
//   table entry at amount minus coin and, unless the coin is too large (or
//   zero), updates the best count; then it writes the entry. The coin store
//   and the table each have registered read data. One item is in work at a time.
//   Reset (aresetn low, synchronous) empties the coin store and drops
//   m_valid; the coin store and table contents need no clearing.
//   A stalled receiver holds the result register; a new item is still taken
//   in the cycle the pending result leaves, and a solve waits at its last
//   step until the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module min_coin_change_solver import mccs_pkg::*; #(
    parameter int MAX_COINS  = DEF_MAX_COINS,
    parameter int MAX_AMOUNT = DEF_MAX_AMOUNT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [OP_W-1:0]  s_operation,
    input  wire logic [VAL_W-1:0] s_coin_value,
    input  wire logic [VAL_W-1:0] s_target_amount,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [VAL_W-1:0]      m_min_coins,
    output logic [ST_W-1:0]       m_status
);

    localparam int CNT_W     = $clog2(MAX_COINS + 1);
    localparam int CIDX_W    = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int TBL_DEPTH = ((MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023) + 1;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    // Sequencer and datapath registers
    upc_t               upc_reg, upc_next;
    logic [CNT_W-1:0]   coin_count_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [AMT_W-1:0]   amt_reg;
    logic [VAL_W-1:0]   tgt_reg;
    logic [BEST_W-1:0]  best_reg;
    logic               m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]   m_min_coins_reg;
    logic [ST_W-1:0]    m_status_reg;

    // Memories with registered read data
    logic [VAL_W-1:0]   coin_mem [MAX_COINS];
    logic [BEST_W-1:0]  tbl_mem  [TBL_DEPTH];
    logic [VAL_W-1:0]   coin_q;
    logic [BEST_W-1:0]  tbl_q;

    ucode_t             uc;
    logic               out_free;
    logic               accept;
    logic               fire;
    logic               cond_hit;
    logic               store_full;
    logic               tgt_too_big;
    logic               coin_add_ok;
    logic               solve_start;
    logic [ST_W-1:0]    acc_status;
    logic               coin_skip;
    logic [AMT_W-1:0]   rd_diff;
    logic [BEST_W-1:0]  tbl_inc;
    logic               tbl_we;
    logic [TBL_AW-1:0]  tbl_waddr;
    logic [BEST_W-1:0]  tbl_wdata;

    // Control word decode and handshakes
    assign uc       = ucode_rom(upc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (uc.wt == W_INPUT) && out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        unique case (uc.wt)
            W_INPUT:  fire = accept;
            W_OUTPUT: fire = out_free;
            default:  fire = 1'b1;
        endcase
    end

    // Item decode at accept
    assign store_full  = (coin_count_reg == CNT_W'(MAX_COINS));
    assign tgt_too_big = (32'(s_target_amount) > 32'(MAX_AMOUNT));
    assign coin_add_ok = (s_coin_value != '0) && !store_full;
    assign solve_start = (s_operation == OP_SOLVE) && (coin_count_reg != '0) && !tgt_too_big;

    // Status of an item that finishes at accept
    always_comb begin
        priority if (s_operation == OP_ADD && !coin_add_ok) begin
            acc_status = ST_REJECT;
        end else if (s_operation == OP_SOLVE && coin_count_reg == '0) begin
            acc_status = ST_NO_COINS;
        end else if (s_operation == OP_SOLVE && tgt_too_big) begin
            acc_status = ST_UNREACH;
        end else begin
            acc_status = ST_OK;
        end
    end

    // Result valid: set by a finished item, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (fire && uc.act == A_ACCEPT) begin
            m_valid_next = !solve_start;
        end else if (fire && uc.act == A_RESULT) begin
            m_valid_next = 1'b1;
        end
    end

    // Coin test and table arithmetic
    assign coin_skip = (coin_q == '0) || ({1'b0, coin_q} > amt_reg);
    assign rd_diff   = amt_reg - {1'b0, coin_q};
    assign tbl_inc   = tbl_q + BEST_W'(1);

    // Jump condition select
    always_comb begin
        unique case (uc.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_DONE_NOW:   cond_hit = !solve_start;
            C_AMT_GT_TGT: cond_hit = (amt_reg > {1'b0, tgt_reg});
            C_K_DONE:     cond_hit = (k_reg == coin_count_reg);
            C_COIN_SKIP:  cond_hit = coin_skip;
            default:      cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        upc_next = upc_reg;
        if (fire) begin
            upc_next = cond_hit ? uc.jump : upc_reg + upc_t'(1);
        end
    end

    // Table write port: entry zero at solve start, one entry per amount
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = amt_reg[TBL_AW-1:0];
        tbl_wdata = best_reg;
        if (fire && uc.act == A_ACCEPT && solve_start) begin
            tbl_we    = 1'b1;
            tbl_waddr = '0;
            tbl_wdata = '0;
        end else if (fire && uc.act == A_TBL_WR) begin
            tbl_we = 1'b1;
        end
    end

    // Control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg        <= U_WAIT;
            coin_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            m_valid_reg <= m_valid_next;
            if (fire) begin
                unique case (uc.act)
                    A_ACCEPT: begin
                        m_min_coins_reg <= '0;
                        m_status_reg    <= acc_status;
                        if (s_operation == OP_ADD && coin_add_ok) begin
                            coin_count_reg <= coin_count_reg + CNT_W'(1);
                        end else if (s_operation == OP_CLEAR) begin
                            coin_count_reg <= '0;
                        end
                        tgt_reg  <= s_target_amount;
                        best_reg <= '0;
                        amt_reg  <= AMT_W'(1);
                    end
                    A_BEST_INIT: begin
                        best_reg <= BEST_UNREACH;
                        k_reg    <= '0;
                    end
                    A_TBL_RD: begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                    A_BEST_UPD: begin
                        if (tbl_q != BEST_UNREACH && tbl_inc < best_reg) begin
                            best_reg <= tbl_inc;
                        end
                    end
                    A_TBL_WR: begin
                        amt_reg <= amt_reg + AMT_W'(1);
                    end
                    A_RESULT: begin
                        if (best_reg == BEST_UNREACH) begin
                            m_min_coins_reg <= '0;
                            m_status_reg    <= ST_UNREACH;
                        end else begin
                            m_min_coins_reg <= best_reg[VAL_W-1:0];
                            m_status_reg    <= ST_OK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Coin store: written on a good add, read at the coin index
    always_ff @(posedge aclk) begin
        if (fire && uc.act == A_ACCEPT && s_operation == OP_ADD && coin_add_ok) begin
            coin_mem[coin_count_reg[CIDX_W-1:0]] <= s_coin_value;
        end
        if (fire && uc.act == A_COIN_RD) begin
            coin_q <= coin_mem[k_reg[CIDX_W-1:0]];
        end
    end

    // Best-count table: one write and one read port
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (fire && uc.act == A_TBL_RD) begin
            tbl_q <= tbl_mem[rd_diff[TBL_AW-1:0]];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_min_coins = m_min_coins_reg;
    assign m_status    = m_status_reg;

endmodule

`default_nettype wire

FILE: rtl/mccs_checker.sv
// Port-level checks for the minimum coin change solver.
// Depends on mccs_pkg for codes; bound to min_coin_change_solver below.
`timescale 1ns / 1ps
`default_nettype none

module mccs_checker import mccs_pkg::*; (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic [OP_W-1:0]  s_operation,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [VAL_W-1:0] m_min_coins,
    input wire logic [ST_W-1:0]  m_status
);

    // A stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_coins) && $stable(m_status))
        else $error("result item changed while stalled");

    // Non-solve items answer in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation != OP_SOLVE |=> m_valid)
        else $error("non-solve item gave no result in the next cycle");

    // A nonzero count only comes with an ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_min_coins != '0 |-> m_status == ST_OK)
        else $error("nonzero count with error status");

    // Reset drops the result channel
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind min_coin_change_solver mccs_checker u_mccs_checker (.*);

`default_nettype wire
